FILE: sv/image_to_column_unfold_defines.svh
// Assertion macros used by the unfold engine's top RTL file.
`ifndef IMAGE_TO_COLUMN_UNFOLD_DEFINES_SVH
`define IMAGE_TO_COLUMN_UNFOLD_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IM2COL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IM2COL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/im2col_pkg.sv
// Types, constants and helper functions of the im2col unfold engine.
`default_nettype none

package im2col_pkg;

    localparam int IMAGE_WORDS  = 16384;
    localparam int MAX_KERNEL   = 8;
    localparam int MAX_CHANNELS = 256;
    localparam int ADDR_W       = $clog2(IMAGE_WORDS);
    localparam int SIZE_MAX     = 1024;
    localparam int REG_ADDR_W   = 5;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_UNFOLD = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        REG_IMAGE_HEIGHT = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_KERNEL_ROWS  = 3'd2,
        REG_KERNEL_COLS  = 3'd3,
        REG_PAD_ROWS     = 3'd4,
        REG_PAD_COLS     = 3'd5,
        REG_STEP_ROWS    = 3'd6,
        REG_STEP_COLS    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [10:0] image_height;
        logic [10:0] image_width;
        logic [3:0]  kernel_rows;
        logic [3:0]  kernel_cols;
        logic [2:0]  pad_rows;
        logic [2:0]  pad_cols;
        logic [3:0]  step_rows;
        logic [3:0]  step_cols;
    } cfg_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [13:0] pixel_address;
        logic [31:0] pixel_value;
        logic [7:0]  channel_index;
        logic [9:0]  out_row;
        logic [9:0]  out_col;
        logic [31:0] col_base;
    } item_t;

    typedef struct packed {
        logic [31:0] col_address;
        logic [31:0] col_value;
        logic        last_tap;
        logic        beyond_store;
    } result_t;

    typedef struct packed {
        logic        busy;
        logic [10:0] rows;
        logic [10:0] cols;
    } grid_status_t;

    function automatic logic [10:0] eff_size(input logic [10:0] v);
        logic [10:0] r;
        if (v == 11'd0)
        begin
            r = 11'd1;
        end
        else if (v > 11'(SIZE_MAX))
        begin
            r = 11'(SIZE_MAX);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [3:0] eff_kernel(input logic [3:0] v);
        logic [3:0] r;
        if (v == 4'd0)
        begin
            r = 4'd1;
        end
        else if (v > 4'(MAX_KERNEL))
        begin
            r = 4'(MAX_KERNEL);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [3:0] eff_step(input logic [3:0] v);
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/im2col_grid.sv
// Output grid size unit: an iterative divider that works out the grid rows and columns.
`default_nettype none

module im2col_grid (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  im2col_pkg::cfg_t           cfg,
    output im2col_pkg::grid_status_t   status
);
    import im2col_pkg::*;

    localparam int SPAN_W    = 11;
    localparam int DIV_STEPS = SPAN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Lane 0 works on the rows, lane 1 on the columns.
    logic [SPAN_W-1:0] span     [2];
    logic [SPAN_W-1:0] ksize    [2];
    logic [3:0]        divisor  [2];
    logic [4:0]        rem_shift[2];
    logic              fits     [2];
    logic [3:0]        rem_next [2];
    logic [SPAN_W-1:0] num_next [2];

    logic [SPAN_W-1:0] num_reg  [2];
    logic [3:0]        den_reg  [2];
    logic [3:0]        rem_reg  [2];
    logic              under_reg[2];
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [SPAN_W-1:0] rows_reg;
    logic [SPAN_W-1:0] cols_reg;

    always_comb
    begin
        span[0]    = eff_size(cfg.image_height) + SPAN_W'({cfg.pad_rows, 1'b0});
        span[1]    = eff_size(cfg.image_width) + SPAN_W'({cfg.pad_cols, 1'b0});
        ksize[0]   = SPAN_W'(eff_kernel(cfg.kernel_rows));
        ksize[1]   = SPAN_W'(eff_kernel(cfg.kernel_cols));
        divisor[0] = eff_step(cfg.step_rows);
        divisor[1] = eff_step(cfg.step_cols);
        for (int i = 0; i < 2; i++)
        begin
            rem_shift[i] = {rem_reg[i], num_reg[i][SPAN_W-1]};
            fits[i]      = rem_shift[i] >= {1'b0, den_reg[i]};
            rem_next[i]  = fits[i] ? 4'(rem_shift[i] - {1'b0, den_reg[i]}) : rem_shift[i][3:0];
            num_next[i]  = {num_reg[i][SPAN_W-2:0], fits[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rows_reg <= SPAN_W'(1);
            cols_reg <= SPAN_W'(1);
            for (int i = 0; i < 2; i++)
            begin
                num_reg[i]   <= '0;
                den_reg[i]   <= 4'd1;
                rem_reg[i]   <= '0;
                under_reg[i] <= 1'b0;
            end
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_STEPS);
            for (int i = 0; i < 2; i++)
            begin
                under_reg[i] <= span[i] < ksize[i];
                num_reg[i]   <= span[i] - ksize[i];
                den_reg[i]   <= divisor[i];
                rem_reg[i]   <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                for (int i = 0; i < 2; i++)
                begin
                    num_reg[i] <= num_next[i];
                    rem_reg[i] <= rem_next[i];
                end
            end
            else
            begin
                // A kernel larger than the padded plane leaves no output position.
                rows_reg <= under_reg[0] ? '0 : num_reg[0] + SPAN_W'(1);
                cols_reg <= under_reg[1] ? '0 : num_reg[1] + SPAN_W'(1);
                busy_reg <= 1'b0;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.rows = rows_reg;
    assign status.cols = cols_reg;

endmodule

`default_nettype wire

FILE: sv/image_to_column_unfold.sv
// im2col unfold engine: config registers, image store and the per-tap sequencer.
//
// A write word lands in the image store, which is not cleared after reset. An unfold
// word keeps the block busy while the setup states (grid, index, multiply, sum, base)
// build the start addresses, with up to four multiplications in the grid state; then
// one tap a cycle, while the catching stage is free or moving on, is issued and, if it
// lies in the image and the store, read through the single read port of the store.
// An unfold word outside the output grid gives no result. Each result goes through the
// catching stage and the result register once its tap is issued, and results stall
// without loss when the receiver holds off. After a configuration write the grid size
// is recomputed by an iterative divider and no word is taken until it is done.
`default_nettype none
`include "image_to_column_unfold_defines.svh"

module image_to_column_unfold (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  im2col_pkg::item_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output im2col_pkg::result_t                 result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [im2col_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import im2col_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_GRID,
        ST_SETUP_INDEX,
        ST_SETUP_MUL,
        ST_SETUP_SUM,
        ST_SETUP_BASE,
        ST_TAP
    } state_t;

    cfg_t         cfg_reg;
    logic         cfg_pend_reg;
    logic         cfg_wr;
    cfg_reg_t     reg_sel;
    grid_status_t grid;

    logic [10:0] eff_h;
    logic [10:0] eff_w;
    logic [3:0]  eff_kr;
    logic [3:0]  eff_kc;
    logic [3:0]  eff_sr;
    logic [3:0]  eff_sc;

    state_t             state_reg;
    item_t              item_reg;
    logic signed [15:0] h0_reg;
    logic signed [15:0] w0_reg;
    logic [6:0]         kk_reg;
    logic [18:0]        chh_reg;
    logic [14:0]        chkk_reg;
    logic [31:0]        r0_reg;
    logic [21:0]        stride_reg;
    logic [25:0]        rowmul_reg;
    logic [31:0]        rw_reg;
    logic [31:0]        ta_reg;
    logic [3:0]         tap_p_reg;
    logic [3:0]         tap_j_reg;
    logic signed [15:0] h_reg;
    logic signed [15:0] w_reg;
    logic [31:0]        ia_reg;
    logic [31:0]        caddr_reg;

    logic        s1_valid_reg;
    logic [31:0] s1_caddr_reg;
    logic        s1_last_reg;
    logic        s1_beyond_reg;
    logic        s1_mem_reg;
    logic [31:0] rd_data_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    logic [31:0] image_store [IMAGE_WORDS];

    logic item_acc;
    logic mem_we;
    logic tap_in_image;
    logic tap_in_store;
    logic tap_last;
    logic tap_row_end;
    logic s1_adv;
    logic issue;
    logic rd_en;
    logic out_of_grid;

    // ---------------------------------------------------------------- registers
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[REG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_height <= 11'd1;
            cfg_reg.image_width  <= 11'd1;
            cfg_reg.kernel_rows  <= 4'd1;
            cfg_reg.kernel_cols  <= 4'd1;
            cfg_reg.pad_rows     <= 3'd0;
            cfg_reg.pad_cols     <= 3'd0;
            cfg_reg.step_rows    <= 4'd1;
            cfg_reg.step_cols    <= 4'd1;
            cfg_pend_reg         <= 1'b0;
        end
        else
        begin
            cfg_pend_reg <= cfg_wr;
            if (cfg_wr)
            begin
                unique case (reg_sel)
                    REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[10:0];
                    REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[10:0];
                    REG_KERNEL_ROWS:  cfg_reg.kernel_rows  <= pwdata[3:0];
                    REG_KERNEL_COLS:  cfg_reg.kernel_cols  <= pwdata[3:0];
                    REG_PAD_ROWS:     cfg_reg.pad_rows     <= pwdata[2:0];
                    REG_PAD_COLS:     cfg_reg.pad_cols     <= pwdata[2:0];
                    REG_STEP_ROWS:    cfg_reg.step_rows    <= pwdata[3:0];
                    REG_STEP_COLS:    cfg_reg.step_cols    <= pwdata[3:0];
                    default:          cfg_reg              <= cfg_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            REG_KERNEL_ROWS:  prdata = 32'(cfg_reg.kernel_rows);
            REG_KERNEL_COLS:  prdata = 32'(cfg_reg.kernel_cols);
            REG_PAD_ROWS:     prdata = 32'(cfg_reg.pad_rows);
            REG_PAD_COLS:     prdata = 32'(cfg_reg.pad_cols);
            REG_STEP_ROWS:    prdata = 32'(cfg_reg.step_rows);
            REG_STEP_COLS:    prdata = 32'(cfg_reg.step_cols);
            default:          prdata = '0;
        endcase
    end

    // The grid unit starts in the cycle after the write, once the register holds the new value.
    im2col_grid u_grid (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_pend_reg),
        .cfg    (cfg_reg),
        .status (grid)
    );

    assign eff_h  = eff_size(cfg_reg.image_height);
    assign eff_w  = eff_size(cfg_reg.image_width);
    assign eff_kr = eff_kernel(cfg_reg.kernel_rows);
    assign eff_kc = eff_kernel(cfg_reg.kernel_cols);
    assign eff_sr = eff_step(cfg_reg.step_rows);
    assign eff_sc = eff_step(cfg_reg.step_cols);

    // ---------------------------------------------------------------- control
    assign item_ready = (state_reg == ST_IDLE) && !cfg_pend_reg && !grid.busy;
    assign item_acc   = item_valid && item_ready;
    assign mem_we     = item_acc && (item.opcode == OP_WRITE)
                        && (32'(item.pixel_address) < 32'(IMAGE_WORDS));

    assign out_of_grid = ({1'b0, item_reg.out_row} >= grid.rows)
                         || ({1'b0, item_reg.out_col} >= grid.cols)
                         || (32'(item_reg.channel_index) >= 32'(MAX_CHANNELS));

    assign tap_in_image = !h_reg[15] && !w_reg[15]
                          && (h_reg < $signed(16'(eff_h)))
                          && (w_reg < $signed(16'(eff_w)));
    assign tap_in_store = ia_reg < 32'(IMAGE_WORDS);
    assign tap_row_end  = (tap_j_reg + 4'd1) == eff_kc;
    assign tap_last     = tap_row_end && ((tap_p_reg + 4'd1) == eff_kr);

    // A tap is read only when the stage that catches the read word is free or moving on.
    assign s1_adv = !result_valid_reg || result_ready;
    assign issue  = (state_reg == ST_TAP) && (!s1_valid_reg || s1_adv);
    assign rd_en  = issue && tap_in_image && tap_in_store;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            item_reg         <= '0;
            h0_reg           <= '0;
            w0_reg           <= '0;
            kk_reg           <= '0;
            chh_reg          <= '0;
            chkk_reg         <= '0;
            r0_reg           <= '0;
            stride_reg       <= '0;
            rowmul_reg       <= '0;
            rw_reg           <= '0;
            ta_reg           <= '0;
            tap_p_reg        <= '0;
            tap_j_reg        <= '0;
            h_reg            <= '0;
            w_reg            <= '0;
            ia_reg           <= '0;
            caddr_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            s1_caddr_reg     <= '0;
            s1_last_reg      <= 1'b0;
            s1_beyond_reg    <= 1'b0;
            s1_mem_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_acc && (item.opcode == OP_UNFOLD))
                    begin
                        item_reg  <= item;
                        state_reg <= ST_SETUP_GRID;
                    end
                end
                ST_SETUP_GRID:
                begin
                    h0_reg  <= $signed({2'b00, 14'(item_reg.out_row) * 14'(eff_sr)})
                               - $signed({13'd0, cfg_reg.pad_rows});
                    w0_reg  <= $signed({2'b00, 14'(item_reg.out_col) * 14'(eff_sc)})
                               - $signed({13'd0, cfg_reg.pad_cols});
                    kk_reg  <= 7'(eff_kr) * 7'(eff_kc);
                    chh_reg <= 19'(item_reg.channel_index) * 19'(eff_h);
                    state_reg <= out_of_grid ? ST_IDLE : ST_SETUP_INDEX;
                end
                ST_SETUP_INDEX:
                begin
                    chkk_reg   <= 15'(item_reg.channel_index) * 15'(kk_reg);
                    r0_reg     <= 32'(chh_reg) + 32'(h0_reg);
                    stride_reg <= 22'(grid.rows) * 22'(grid.cols);
                    state_reg  <= ST_SETUP_MUL;
                end
                ST_SETUP_MUL:
                begin
                    rowmul_reg <= 26'(chkk_reg) * 26'(grid.rows);
                    rw_reg     <= r0_reg * 32'(eff_w);
                    state_reg  <= ST_SETUP_SUM;
                end
                ST_SETUP_SUM:
                begin
                    ta_reg    <= 32'(27'(rowmul_reg) + 27'(item_reg.out_row)) * 32'(grid.cols);
                    // Image address of the first tap; only its low 32 bits matter.
                    ia_reg    <= 32'(item_reg.pixel_address) + rw_reg + 32'(w0_reg);
                    h_reg     <= h0_reg;
                    w_reg     <= w0_reg;
                    tap_p_reg <= '0;
                    tap_j_reg <= '0;
                    state_reg <= ST_SETUP_BASE;
                end
                ST_SETUP_BASE:
                begin
                    caddr_reg <= item_reg.col_base + ta_reg + 32'(item_reg.out_col);
                    state_reg <= ST_TAP;
                end
                ST_TAP:
                begin
                    if (issue)
                    begin
                        caddr_reg <= caddr_reg + 32'(stride_reg);
                        if (tap_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (tap_row_end)
                        begin
                            tap_j_reg <= '0;
                            tap_p_reg <= tap_p_reg + 4'd1;
                            h_reg     <= h_reg + 16'sd1;
                            w_reg     <= w0_reg;
                            ia_reg    <= ia_reg + 32'(eff_w) - 32'(eff_kc) + 32'd1;
                        end
                        else
                        begin
                            tap_j_reg <= tap_j_reg + 4'd1;
                            w_reg     <= w_reg + 16'sd1;
                            ia_reg    <= ia_reg + 32'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (issue)
            begin
                s1_valid_reg  <= 1'b1;
                s1_caddr_reg  <= caddr_reg;
                s1_last_reg   <= tap_last;
                s1_beyond_reg <= tap_in_image && !tap_in_store;
                s1_mem_reg    <= tap_in_image && tap_in_store;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                result_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    result_reg.col_address  <= s1_caddr_reg;
                    result_reg.col_value    <= s1_mem_reg ? rd_data_reg : '0;
                    result_reg.last_tap     <= s1_last_reg;
                    result_reg.beyond_store <= s1_beyond_reg;
                end
            end
        end
    end

    // ---------------------------------------------------------------- image store
    // Writes are taken only in the idle state and reads only while taps issue, so the
    // two never meet; the read word holds while the catching stage stalls.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            image_store[ADDR_W'(item.pixel_address)] <= item.pixel_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= image_store[ADDR_W'(ia_reg)];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------- checks
    `IM2COL_ASSERT_NEXT(a_read_caught, rd_en, s1_valid_reg && s1_mem_reg, "read word not caught")
    `IM2COL_ASSERT_NOW(a_busy_blocks, grid.busy || cfg_pend_reg, !item_ready, "word taken while grid busy")
    `IM2COL_ASSERT_NEXT(a_last_ends, issue && tap_last, state_reg == ST_IDLE, "last tap did not end the word")
    `IM2COL_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_caddr_reg), "stalled tap lost")

endmodule

`default_nettype wire
